@@ sv/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants and types for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Default number of entries the queue can hold
  localparam int unsigned CAPACITY = 16;

  // Field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned StatW  = 2;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes
  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;

  // One stored entry: priority and value
  typedef struct packed {
    logic        [PrioW-1:0]  prio;
    logic signed [ValueW-1:0] value;
  } entry_t;

endpackage

@@ sv/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Stable min-priority queue kept sorted in a circular buffer in one
// synchronous RAM; removal pops the head, insert shifts larger entries up.
// ----------------------------------------------------------------------------
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------
//  command  | start / busy     | op_i, value_i, priority_req_i
//  result   | done_o (strobe)  | out_value_o, status_o, is_empty_o
//
// A removal reads the head entry from RAM, then shows it. An insert into an
// empty or full queue, or a removal from an empty queue, completes on
// acceptance. Any other insert walks down from the tail, moving each entry
// with a larger priority than the new one up a slot, then writes the new one;
// the single RAM write port moves one entry per cycle. The result strobe
// rises in the cycle after completion. Reset clears the control registers
// only, not the RAM. The receiver cannot stall; busy is high outside idle.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              op_i,
  input  logic signed [spq_pkg::ValueW-1:0] value_i,
  input  logic        [spq_pkg::PrioW-1:0]  priority_req_i,
  output logic                              done_o,
  output logic signed [spq_pkg::ValueW-1:0] out_value_o,
  output logic        [spq_pkg::StatW-1:0]  status_o,
  output logic                              is_empty_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + 1;

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_PLACE = 2'd3;

  // Circular index helpers
  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] a);
    idx_inc = (a == AW'(CAPACITY - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] a);
    idx_dec = (a == '0) ? AW'(CAPACITY - 1) : a - 1'b1;
  endfunction

  logic [1:0]      state_q, state_d;
  logic [AW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   pos_q, pos_d;
  logic [CW-1:0]   left_q, left_d;
  spq_pkg::entry_t new_q, new_d;

  logic                              done_q, done_d;
  logic signed [spq_pkg::ValueW-1:0] res_value_q, res_value_d;
  logic        [spq_pkg::StatW-1:0]  res_stat_q, res_stat_d;
  logic                              res_empty_q, res_empty_d;

  // RAM ports
  spq_pkg::entry_t mem [CAPACITY];
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  spq_pkg::entry_t mem_wd;
  logic [AW-1:0]   mem_ra;
  spq_pkg::entry_t rd_q;

  logic            accept;
  logic [SW-1:0]   tail_sum;
  logic [AW-1:0]   tail_last;
  spq_pkg::entry_t req_entry;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // Index of the last stored entry
  always_comb begin
    tail_sum = SW'(head_q) + SW'(count_q) - SW'(1);
    if (tail_sum >= SW'(CAPACITY)) begin
      tail_sum = tail_sum - SW'(CAPACITY);
    end
    tail_last = tail_sum[AW-1:0];
  end

  assign req_entry.prio  = priority_req_i;
  assign req_entry.value = value_i;

  // Sequencer and RAM control
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    pos_d       = pos_q;
    left_d      = left_q;
    new_d       = new_q;
    done_d      = 1'b0;
    res_value_d = res_value_q;
    res_stat_d  = res_stat_q;
    res_empty_d = res_empty_q;
    mem_we      = 1'b0;
    mem_wa      = pos_q;
    mem_wd      = new_q;
    mem_ra      = head_q;

    case (state_q)
      S_IDLE: begin
        if (op_i == spq_pkg::OP_INSERT) begin
          mem_ra = tail_last;
        end
        if (accept) begin
          if (op_i == spq_pkg::OP_REMOVE) begin
            if (count_q == '0) begin
              done_d      = 1'b1;
              res_value_d = '0;
              res_stat_d  = spq_pkg::ST_EMPTY;
              res_empty_d = 1'b1;
            end else begin
              state_d = S_POP;
            end
          end else if (count_q == CW'(CAPACITY)) begin
            done_d      = 1'b1;
            res_value_d = '0;
            res_stat_d  = spq_pkg::ST_FULL;
            res_empty_d = 1'b0;
          end else if (count_q == '0) begin
            // first entry goes straight to the head slot
            mem_we      = 1'b1;
            mem_wa      = head_q;
            mem_wd      = req_entry;
            count_d     = count_q + 1'b1;
            done_d      = 1'b1;
            res_value_d = '0;
            res_stat_d  = spq_pkg::ST_OK;
            res_empty_d = 1'b0;
          end else begin
            new_d   = req_entry;
            pos_d   = tail_last;
            left_d  = count_q;
            state_d = S_SHIFT;
          end
        end
      end

      S_POP: begin
        head_d      = idx_inc(head_q);
        count_d     = count_q - 1'b1;
        done_d      = 1'b1;
        res_value_d = rd_q.value;
        res_stat_d  = spq_pkg::ST_OK;
        res_empty_d = (count_q == CW'(1));
        state_d     = S_IDLE;
      end

      S_SHIFT: begin
        // rd_q holds the entry at pos_q
        mem_we = 1'b1;
        mem_wa = idx_inc(pos_q);
        if (rd_q.prio > new_q.prio) begin
          mem_wd = rd_q;
          if (left_q == CW'(1)) begin
            state_d = S_PLACE;
          end else begin
            mem_ra = idx_dec(pos_q);
            pos_d  = idx_dec(pos_q);
            left_d = left_q - 1'b1;
          end
        end else begin
          mem_wd      = new_q;
          count_d     = count_q + 1'b1;
          done_d      = 1'b1;
          res_value_d = '0;
          res_stat_d  = spq_pkg::ST_OK;
          res_empty_d = 1'b0;
          state_d     = S_IDLE;
        end
      end

      S_PLACE: begin
        // new entry lands at the head slot
        mem_we      = 1'b1;
        mem_wa      = pos_q;
        mem_wd      = new_q;
        count_d     = count_q + 1'b1;
        done_d      = 1'b1;
        res_value_d = '0;
        res_stat_d  = spq_pkg::ST_OK;
        res_empty_d = 1'b0;
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      left_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      left_q  <= left_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    new_q       <= new_d;
    res_value_q <= res_value_d;
    res_stat_q  <= res_stat_d;
    res_empty_q <= res_empty_d;
  end

  // Entry RAM: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[mem_ra];
  end

  assign done_o      = done_q;
  assign out_value_o = res_value_q;
  assign status_o    = res_stat_q;
  assign is_empty_o  = res_empty_q;

`ifndef ASSERT_OFF
  // Fill count never passes the capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A result is shown only once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // Removal from an empty queue reports at once
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == spq_pkg::OP_REMOVE && count_q == '0)
      |=> (done_o && status_o == spq_pkg::ST_EMPTY && is_empty_o))
    else $error("empty removal not reported");

  // RAM is written only by an accepted transaction or an insert in flight
  a_we_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (accept || state_q == S_SHIFT || state_q == S_PLACE))
    else $error("stray RAM write");

  // Shift walk always has an entry left to examine
  a_shift_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (left_q != '0 && left_q <= count_q))
    else $error("shift walk out of range");
`endif

endmodule

@@ sim/sorted_priority_queue_test.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_test
// Self-checking bench for the sorted priority queue. A directed sequence walks
// the empty and full corners, ties, and extreme values and priorities. Random
// segments follow, biased toward filling, draining or churning the queue. A
// shadow copy of the sorted store predicts each result. Every strobed result
// is compared field by field, in order, against the predicted outcome.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Command as seen by the block, plus a marker that makes the sender drain
  typedef struct {
    logic                              op;
    logic signed [spq_pkg::ValueW-1:0] value;
    logic        [spq_pkg::PrioW-1:0]  prio;
    bit                                drain;
  } cmd_t;

  // One result transaction
  typedef struct {
    logic signed [spq_pkg::ValueW-1:0] value;
    logic        [spq_pkg::StatW-1:0]  status;
    logic                              empty;
  } outcome_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              op_i = spq_pkg::OP_INSERT;
  logic signed [spq_pkg::ValueW-1:0] value_i = '0;
  logic        [spq_pkg::PrioW-1:0]  priority_req_i = '0;
  logic                              done_o;
  logic signed [spq_pkg::ValueW-1:0] out_value_o;
  logic        [spq_pkg::StatW-1:0]  status_o;
  logic                              is_empty_o;

  sorted_priority_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .value_i        (value_i),
    .priority_req_i (priority_req_i),
    .done_o         (done_o),
    .out_value_o    (out_value_o),
    .status_o       (status_o),
    .is_empty_o     (is_empty_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the sorted store, in service order
  logic signed [spq_pkg::ValueW-1:0] shadow_values [spq_pkg::CAPACITY];
  logic        [spq_pkg::PrioW-1:0]  shadow_prios  [spq_pkg::CAPACITY];
  int unsigned                       shadow_count = 0;

  cmd_t     pending_cmds [$];
  outcome_t queue_outcomes [$];
  cmd_t     issued_cmd;

  int burst_left = 8;
  int gap_left = 0;
  int mismatch_count = 0;
  int n_inserts = 0;
  int n_removals = 0;
  int n_full_drops = 0;
  int n_empty_removals = 0;
  int n_results = 0;

  // Apply one command to the shadow store and return what the block reports
  function automatic outcome_t serve_command(cmd_t c);
    outcome_t    r;
    int unsigned slot;
    int unsigned k;
    r.value = '0;
    r.status = spq_pkg::ST_OK;
    if (c.op == spq_pkg::OP_REMOVE) begin
      if (shadow_count == 0) begin
        r.status = spq_pkg::ST_EMPTY;
        n_empty_removals++;
      end else begin
        r.value = shadow_values[0];
        for (k = 1; k < shadow_count; k++) begin
          shadow_values[k-1] = shadow_values[k];
          shadow_prios[k-1]  = shadow_prios[k];
        end
        shadow_count--;
        n_removals++;
      end
    end else if (shadow_count >= spq_pkg::CAPACITY) begin
      r.status = spq_pkg::ST_FULL;
      n_full_drops++;
    end else begin
      // new entry goes behind everything of lower or equal priority number
      slot = 0;
      while (slot < shadow_count && shadow_prios[slot] <= c.prio) slot++;
      for (k = shadow_count; k > slot; k--) begin
        shadow_values[k] = shadow_values[k-1];
        shadow_prios[k]  = shadow_prios[k-1];
      end
      shadow_values[slot] = c.value;
      shadow_prios[slot]  = c.prio;
      shadow_count++;
      n_inserts++;
    end
    r.empty = (shadow_count == 0);
    return r;
  endfunction

  task automatic add_cmd(logic op, logic signed [spq_pkg::ValueW-1:0] v,
                         logic [spq_pkg::PrioW-1:0] p);
    cmd_t c;
    c.op = op;
    c.value = v;
    c.prio = p;
    c.drain = 1'b0;
    pending_cmds.push_back(c);
  endtask

  task automatic add_drain();
    cmd_t c;
    c.op = spq_pkg::OP_INSERT;
    c.value = '0;
    c.prio = '0;
    c.drain = 1'b1;
    pending_cmds.push_back(c);
  endtask

  // Driver: issue commands in bursts, hold while busy, drain on a marker
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        queue_outcomes.push_back(serve_command(issued_cmd));
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() != 0 && pending_cmds[0].drain) begin
          start <= 1'b0;
          if (queue_outcomes.size() == 0) void'(pending_cmds.pop_front());
        end else if (pending_cmds.size() != 0) begin
          issued_cmd = pending_cmds.pop_front();
          start <= 1'b1;
          op_i <= issued_cmd.op;
          value_i <= issued_cmd.value;
          priority_req_i <= issued_cmd.prio;
          burst_left--;
          if (burst_left <= 0) begin
            // now and then a long stretch with no idle cycles
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 10);
            gap_left = $urandom_range(0, 5);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result matches the oldest predicted outcome
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o === 1'b1) begin
      n_results++;
      if (queue_outcomes.size() == 0) begin
        $error("result with nothing outstanding: out_value %0d status %0d is_empty %0b",
               out_value_o, status_o, is_empty_o);
        mismatch_count++;
      end else begin
        want = queue_outcomes.pop_front();
        if (out_value_o !== want.value) begin
          $error("out_value: expected %0d, got %0d", want.value, out_value_o);
          mismatch_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatch_count++;
        end
        if (is_empty_o !== want.empty) begin
          $error("is_empty: expected %0b, got %0b", want.empty, is_empty_o);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int n;
    int seg_len;
    int insert_pct;
    int prio_mode;
    logic [spq_pkg::PrioW-1:0] p;
    logic op;

    // removal from an empty queue, ignored fields set to garbage
    add_cmd(spq_pkg::OP_REMOVE, 32'sh7fffffff, 16'hffff);
    // fill to capacity: extremes, ties and alternating bit patterns
    add_cmd(spq_pkg::OP_INSERT, -32'sh80000000, 16'hffff);
    add_cmd(spq_pkg::OP_INSERT, 32'sh7fffffff, 16'h0000);
    add_cmd(spq_pkg::OP_INSERT, 32'sh0, 16'h0000);
    add_cmd(spq_pkg::OP_INSERT, -32'sh1, 16'hffff);
    add_cmd(spq_pkg::OP_INSERT, 32'sh5, 16'd100);
    add_cmd(spq_pkg::OP_INSERT, 32'sh6, 16'd100);
    add_cmd(spq_pkg::OP_INSERT, 32'sh7, 16'd100);
    add_cmd(spq_pkg::OP_INSERT, 32'sh55555555, 16'haaaa);
    add_cmd(spq_pkg::OP_INSERT, 32'shaaaaaaaa, 16'h5555);
    add_cmd(spq_pkg::OP_INSERT, 32'sh1, 16'd1);
    add_cmd(spq_pkg::OP_INSERT, 32'sh2, 16'hfffe);
    add_cmd(spq_pkg::OP_INSERT, 32'sh3, 16'h0000);
    add_cmd(spq_pkg::OP_INSERT, 32'sh4, 16'd100);
    add_cmd(spq_pkg::OP_INSERT, 32'sh8, 16'd100);
    add_cmd(spq_pkg::OP_INSERT, 32'sh9, 16'h8000);
    add_cmd(spq_pkg::OP_INSERT, 32'sha, 16'h7fff);
    // insert into a full queue is dropped
    add_cmd(spq_pkg::OP_INSERT, 32'shb, 16'h0000);
    repeat (5) add_cmd(spq_pkg::OP_REMOVE, $urandom, 16'($urandom));
    add_drain();

    // random segments: fill-heavy, drain-heavy or balanced
    n = 0;
    while (n < 1150) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0: insert_pct = 20;
        1: insert_pct = 50;
        default: insert_pct = 85;
      endcase
      prio_mode = $urandom_range(0, 3);
      repeat (seg_len) begin
        op = ($urandom_range(1, 100) <= insert_pct) ? spq_pkg::OP_INSERT
                                                    : spq_pkg::OP_REMOVE;
        case (prio_mode)
          0: p = 16'($urandom_range(0, 3));
          1: p = 16'($urandom);
          2: begin
            case ($urandom_range(0, 3))
              0: p = 16'h0000;
              1: p = 16'h0001;
              2: p = 16'hfffe;
              default: p = 16'hffff;
            endcase
          end
          default: p = 16'($urandom_range(100, 110));
        endcase
        add_cmd(op, $urandom, p);
        n++;
        if (n % 250 == 0) add_drain();
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || start || queue_outcomes.size() != 0);
    // wait on to catch any stray result
    repeat (30) @(negedge clk_i);

    $display("Ran %0d results: %0d inserts, %0d removals, %0d full-queue drops,",
             n_results, n_inserts, n_removals, n_full_drops);
    $display("  %0d removals from an empty queue, %0d field mismatches",
             n_empty_removals, mismatch_count);
    if (mismatch_count == 0) begin
      $display("sorted_priority_queue verification clean");
    end else begin
      $display("sorted_priority_queue verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3ms;
    $display("sorted_priority_queue verification failed");
    $finish;
  end

endmodule

@@ sorted_priority_queue.f @@
sv/spq_pkg.sv
sv/sorted_priority_queue.sv
sim/sorted_priority_queue_test.sv
